// ===== sv/mclt_pkg.sv =====
// package for the command line tokenizer: payload structs, parse state codes,
// result kind codes and character constants; no dependencies
`timescale 1ns / 1ps

package mclt_pkg;

    // one input request: a character or an end-of-line marker
    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } t_in_item;

    // one result: field character or done event
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch_res;
        logic       first;
        logic       last;
    } t_out_item;

    // parse state codes
    localparam logic [4:0] S_LINE         = 5'd0;
    localparam logic [4:0] S_TOK          = 5'd1;
    localparam logic [4:0] S_OPER         = 5'd2;
    localparam logic [4:0] S_START        = 5'd3;
    localparam logic [4:0] S_ONAME_BEGIN  = 5'd4;
    localparam logic [4:0] S_ONAME_BEGIN2 = 5'd5;
    localparam logic [4:0] S_OPAR_BEGIN   = 5'd6;
    localparam logic [4:0] S_PAR_BEGIN    = 5'd7;
    localparam logic [4:0] S_ONAME        = 5'd8;
    localparam logic [4:0] S_OPAR         = 5'd9;
    localparam logic [4:0] S_ONAME_Q      = 5'd10;
    localparam logic [4:0] S_OPAR_Q       = 5'd11;
    localparam logic [4:0] S_ONAME_QE     = 5'd12;
    localparam logic [4:0] S_OPAR_QE      = 5'd13;
    localparam logic [4:0] S_PAR          = 5'd14;
    localparam logic [4:0] S_PAR_Q        = 5'd15;
    localparam logic [4:0] S_PAR_QE       = 5'd16;

    // result kinds
    localparam logic [2:0] K_TOKEN  = 3'd0;
    localparam logic [2:0] K_OPER   = 3'd1;
    localparam logic [2:0] K_ONAME  = 3'd2;
    localparam logic [2:0] K_OPARAM = 3'd3;
    localparam logic [2:0] K_PARAM  = 3'd4;
    localparam logic [2:0] K_ODONE  = 3'd5;
    localparam logic [2:0] K_PDONE  = 3'd6;
    localparam logic [2:0] K_LDONE  = 3'd7;

    // characters with a meaning to the parser
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_DASH  = 8'h2D;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_BSL   = 8'h5C;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;

    // result queue depth: room for two results of one request plus slack
    localparam int QDEPTH = 4;

endpackage

// ===== sv/mclt_step.sv =====
// next-state and result logic of the tokenizer for one request
// depends on mclt_pkg
`timescale 1ns / 1ps

module mclt_step (
    input  logic [4:0]         i_state,
    input  mclt_pkg::t_in_item i_item,
    output logic [4:0]         o_next_state,
    output logic [1:0]         o_res_cnt,
    output mclt_pkg::t_out_item o_res0,
    output mclt_pkg::t_out_item o_res1
);

    function automatic mclt_pkg::t_out_item mk(input logic [2:0] kind,
                                               input logic [7:0] c,
                                               input logic first);
        mclt_pkg::t_out_item r;
        r.kind   = kind;
        r.ch_res = c;
        r.first  = first;
        r.last   = 1'b0;
        return r;
    endfunction

    logic [7:0] c;
    logic       is_digit;
    logic       is_space;
    logic       is_dash;
    logic       is_quote;
    logic       is_bsl;

    assign c        = i_item.ch;
    assign is_digit = (c >= mclt_pkg::C_ZERO) && (c <= mclt_pkg::C_NINE);
    assign is_space = (c == mclt_pkg::C_SPACE);
    assign is_dash  = (c == mclt_pkg::C_DASH);
    assign is_quote = (c == mclt_pkg::C_QUOTE);
    assign is_bsl   = (c == mclt_pkg::C_BSL);

    // transition and up to two results
    always_comb begin
        mclt_pkg::t_out_item r0;
        mclt_pkg::t_out_item r1;
        logic [1:0]          cnt;
        logic [4:0]          ns;
        logic                do_main;
        logic                do_esc;
        logic [2:0]          esc_kind;
        r0       = '0;
        r1       = '0;
        cnt      = 2'd0;
        ns       = i_state;
        do_main  = 1'b0;
        do_esc   = 1'b0;
        esc_kind = mclt_pkg::K_PARAM;

        if (i_item.line_end) begin
            // flush a pending option (past its leading dashes) or parameter, then line done
            if (i_state inside {mclt_pkg::S_ONAME, mclt_pkg::S_ONAME_Q,
                                mclt_pkg::S_ONAME_QE, mclt_pkg::S_OPAR,
                                mclt_pkg::S_OPAR_Q, mclt_pkg::S_OPAR_QE,
                                mclt_pkg::S_OPAR_BEGIN}) begin
                r0  = mk(mclt_pkg::K_ODONE, 8'd0, 1'b0);
                r1  = mk(mclt_pkg::K_LDONE, 8'd0, 1'b0);
                cnt = 2'd2;
            end else if (i_state inside {mclt_pkg::S_PAR, mclt_pkg::S_PAR_Q,
                                         mclt_pkg::S_PAR_QE}) begin
                r0  = mk(mclt_pkg::K_PDONE, 8'd0, 1'b0);
                r1  = mk(mclt_pkg::K_LDONE, 8'd0, 1'b0);
                cnt = 2'd2;
            end else begin
                r0  = mk(mclt_pkg::K_LDONE, 8'd0, 1'b0);
                cnt = 2'd1;
            end
            ns = mclt_pkg::S_LINE;
        end else begin
            case (i_state)
                mclt_pkg::S_TOK: begin
                    if (is_digit) begin
                        r0  = mk(mclt_pkg::K_TOKEN, c, 1'b0);
                        cnt = 2'd1;
                    end else if (is_dash) begin
                        r0  = mk(mclt_pkg::K_OPER, c, 1'b1);
                        cnt = 2'd1;
                        ns  = mclt_pkg::S_OPER;
                    end else begin
                        do_main = 1'b1;
                    end
                end
                mclt_pkg::S_OPER: begin
                    if (is_space) begin
                        ns = mclt_pkg::S_START;
                    end else begin
                        r0  = mk(mclt_pkg::K_OPER, c, 1'b0);
                        cnt = 2'd1;
                    end
                end
                mclt_pkg::S_START: begin
                    do_main = 1'b1;
                end
                mclt_pkg::S_ONAME_BEGIN: begin
                    if (is_space) begin
                        ns = mclt_pkg::S_START;
                    end else begin
                        r0  = mk(mclt_pkg::K_ONAME, c, 1'b0);
                        cnt = 2'd1;
                        ns  = is_dash  ? mclt_pkg::S_ONAME_BEGIN2 :
                              is_quote ? mclt_pkg::S_ONAME_Q : mclt_pkg::S_ONAME;
                    end
                end
                mclt_pkg::S_ONAME_BEGIN2: begin
                    if (is_space) begin
                        ns = mclt_pkg::S_PAR_BEGIN;
                    end else begin
                        r0  = mk(mclt_pkg::K_ONAME, c, 1'b0);
                        cnt = 2'd1;
                        ns  = mclt_pkg::S_ONAME;
                    end
                end
                mclt_pkg::S_OPAR_BEGIN: begin
                    if (is_dash) begin
                        // new option closes the pending one
                        r0  = mk(mclt_pkg::K_ODONE, 8'd0, 1'b0);
                        r1  = mk(mclt_pkg::K_ONAME, c, 1'b1);
                        cnt = 2'd2;
                        ns  = mclt_pkg::S_ONAME_BEGIN;
                    end else if (!is_space) begin
                        r0  = mk(mclt_pkg::K_OPARAM, c, 1'b1);
                        cnt = 2'd1;
                        ns  = is_quote ? mclt_pkg::S_OPAR_Q : mclt_pkg::S_OPAR;
                    end
                end
                mclt_pkg::S_PAR_BEGIN: begin
                    if (!is_space) begin
                        r0  = mk(mclt_pkg::K_PARAM, c, 1'b1);
                        cnt = 2'd1;
                        ns  = is_quote ? mclt_pkg::S_PAR_Q : mclt_pkg::S_PAR;
                    end
                end
                mclt_pkg::S_PAR: begin
                    if (is_space) begin
                        r0  = mk(mclt_pkg::K_PDONE, 8'd0, 1'b0);
                        cnt = 2'd1;
                        ns  = mclt_pkg::S_PAR_BEGIN;
                    end else begin
                        r0  = mk(mclt_pkg::K_PARAM, c, 1'b0);
                        cnt = 2'd1;
                    end
                end
                mclt_pkg::S_PAR_Q: begin
                    if (is_bsl) begin
                        ns = mclt_pkg::S_PAR_QE;
                    end else if (is_quote) begin
                        r0  = mk(mclt_pkg::K_PARAM, c, 1'b0);
                        r1  = mk(mclt_pkg::K_PDONE, 8'd0, 1'b0);
                        cnt = 2'd2;
                        ns  = mclt_pkg::S_PAR_BEGIN;
                    end else begin
                        r0  = mk(mclt_pkg::K_PARAM, c, 1'b0);
                        cnt = 2'd1;
                    end
                end
                mclt_pkg::S_PAR_QE: begin
                    do_esc   = 1'b1;
                    esc_kind = mclt_pkg::K_PARAM;
                    ns       = mclt_pkg::S_PAR_Q;
                end
                mclt_pkg::S_ONAME: begin
                    if (is_space) begin
                        ns = mclt_pkg::S_OPAR_BEGIN;
                    end else begin
                        r0  = mk(mclt_pkg::K_ONAME, c, 1'b0);
                        cnt = 2'd1;
                    end
                end
                mclt_pkg::S_ONAME_Q: begin
                    if (is_bsl) begin
                        ns = mclt_pkg::S_ONAME_QE;
                    end else begin
                        r0  = mk(mclt_pkg::K_ONAME, c, 1'b0);
                        cnt = 2'd1;
                        if (is_quote) begin
                            ns = mclt_pkg::S_OPAR_BEGIN;
                        end
                    end
                end
                mclt_pkg::S_ONAME_QE: begin
                    do_esc   = 1'b1;
                    esc_kind = mclt_pkg::K_ONAME;
                    ns       = mclt_pkg::S_ONAME_Q;
                end
                mclt_pkg::S_OPAR: begin
                    if (is_space) begin
                        r0  = mk(mclt_pkg::K_ODONE, 8'd0, 1'b0);
                        cnt = 2'd1;
                        ns  = mclt_pkg::S_START;
                    end else begin
                        r0  = mk(mclt_pkg::K_OPARAM, c, 1'b0);
                        cnt = 2'd1;
                    end
                end
                mclt_pkg::S_OPAR_Q: begin
                    if (is_bsl) begin
                        ns = mclt_pkg::S_OPAR_QE;
                    end else if (is_quote) begin
                        r0  = mk(mclt_pkg::K_OPARAM, c, 1'b0);
                        r1  = mk(mclt_pkg::K_ODONE, 8'd0, 1'b0);
                        cnt = 2'd2;
                        ns  = mclt_pkg::S_START;
                    end else begin
                        r0  = mk(mclt_pkg::K_OPARAM, c, 1'b0);
                        cnt = 2'd1;
                    end
                end
                mclt_pkg::S_OPAR_QE: begin
                    do_esc   = 1'b1;
                    esc_kind = mclt_pkg::K_OPARAM;
                    ns       = mclt_pkg::S_OPAR_Q;
                end
                default: begin
                    // line start, and any unused code
                    if (is_digit) begin
                        r0  = mk(mclt_pkg::K_TOKEN, c, 1'b1);
                        cnt = 2'd1;
                        ns  = mclt_pkg::S_TOK;
                    end else if (is_dash) begin
                        r0  = mk(mclt_pkg::K_OPER, c, 1'b1);
                        cnt = 2'd1;
                        ns  = mclt_pkg::S_OPER;
                    end else begin
                        do_main = 1'b1;
                    end
                end
            endcase

            // start of an option or a plain parameter
            if (do_main) begin
                if (is_space) begin
                    ns = mclt_pkg::S_START;
                end else if (is_dash) begin
                    r0  = mk(mclt_pkg::K_ONAME, c, 1'b1);
                    cnt = 2'd1;
                    ns  = mclt_pkg::S_ONAME_BEGIN;
                end else begin
                    r0  = mk(mclt_pkg::K_PARAM, c, 1'b1);
                    cnt = 2'd1;
                    ns  = is_quote ? mclt_pkg::S_PAR_Q : mclt_pkg::S_PAR;
                end
            end

            // escaped character: backslash kept unless a quote is escaped
            if (do_esc) begin
                if (is_quote) begin
                    r0  = mk(esc_kind, c, 1'b0);
                    cnt = 2'd1;
                end else begin
                    r0  = mk(esc_kind, mclt_pkg::C_BSL, 1'b0);
                    r1  = mk(esc_kind, c, 1'b0);
                    cnt = 2'd2;
                end
            end
        end

        // mark the final result of this request
        if (cnt == 2'd2) begin
            r1.last = 1'b1;
        end else if (cnt == 2'd1) begin
            r0.last = 1'b1;
        end

        o_res0       = r0;
        o_res1       = r1;
        o_res_cnt    = cnt;
        o_next_state = ns;
    end

endmodule

// ===== sv/mclt_out_queue.sv =====
// result queue: takes up to two results per cycle, hands out one per cycle while i_ready is high
// depends on mclt_pkg
`timescale 1ns / 1ps

module mclt_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_cnt,
    input  mclt_pkg::t_out_item i_d0,
    input  mclt_pkg::t_out_item i_d1,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output mclt_pkg::t_out_item o_head
);

    localparam int PW = $clog2(mclt_pkg::QDEPTH);
    localparam int CW = $clog2(mclt_pkg::QDEPTH + 1);

    mclt_pkg::t_out_item r_mem [mclt_pkg::QDEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] r_rd;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          pop;
    logic [PW-1:0] wr1;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_space = (r_cnt <= CW'(mclt_pkg::QDEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign wr1     = r_wr + PW'(1);

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr + PW'(i_push_cnt);
        n_rd  = r_rd + PW'(pop);
        n_cnt = r_cnt + CW'(i_push_cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage write, one or two entries
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_d0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr1] <= i_d1;
        end
    end

endmodule

// ===== sv/mi_command_line_tokenizer.sv =====
// Command line tokenizer, one character or end-of-line marker per request.
// A request passes through the input register and the result queue on its way to the output.
// Throughput: one request per cycle when it gives one result and the output is not stalled;
// a request that gives two results is handed out one result per cycle while the output is ready.
// Reset (synchronous, active low): parse state to line start, input register and result queue empty.
// Top level; depends on mclt_pkg, mclt_step, mclt_out_queue.
`timescale 1ns / 1ps

module mi_command_line_tokenizer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mclt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mclt_pkg::t_out_item o_out_item
);

    logic                r_in_valid;
    mclt_pkg::t_in_item  r_in_item;
    logic [4:0]          r_state;
    logic [4:0]          n_state;
    logic [1:0]          res_cnt;
    mclt_pkg::t_out_item res0;
    mclt_pkg::t_out_item res1;
    logic                q_space;
    logic                consume;
    logic [1:0]          push_cnt;

    assign consume    = r_in_valid && q_space;
    assign o_in_ready = !r_in_valid || consume;
    assign push_cnt   = consume ? res_cnt : 2'd0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // parse state advances when the held request is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mclt_pkg::S_LINE;
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    mclt_step u_step (
        .i_state      (r_state),
        .i_item       (r_in_item),
        .o_next_state (n_state),
        .o_res_cnt    (res_cnt),
        .o_res0       (res0),
        .o_res1       (res1)
    );

    mclt_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_d0       (res0),
        .i_d1       (res1),
        .o_space    (q_space),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_head     (o_out_item)
    );

endmodule
